// ===== src/srhgu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package srhgu_pkg;

    localparam int GRID_SIDE  = 256;
    localparam int GRID_W     = $clog2(GRID_SIDE);
    localparam int ADDR_W     = 2 * GRID_W;
    localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int MAX_RES    = 64;
    localparam int CORDIC_N   = 16;
    localparam int DIV_N      = 23;

    localparam logic [3:0] CNT_SAT    = 4'd15;
    localparam logic [3:0] CNT_FLOOR  = 4'd0;
    localparam logic [3:0] HIMM_RESET = 4'd7;
    localparam logic [3:0] HIMM_HIT   = 4'd3;

    localparam logic [0:0] REG_MAX_RANGE = 1'd0;
    localparam logic [0:0] REG_HALF_BAND = 1'd1;

    // Beam angles in sixteenths of a degree.
    function automatic logic signed [13:0] beam_angle(input logic [2:0] b);
        logic signed [13:0] a;
        case (b)
            3'd0:    a = 14'sd1440;
            3'd1:    a = 14'sd800;
            3'd2:    a = 14'sd480;
            3'd3:    a = 14'sd160;
            3'd4:    a = -14'sd160;
            3'd5:    a = -14'sd480;
            3'd6:    a = -14'sd800;
            default: a = -14'sd1440;
        endcase
        return a;
    endfunction

    // Arctangent of 2^-k in Q16 degrees.
    function automatic logic [22:0] atan_q16(input logic [3:0] k);
        logic [22:0] r;
        case (k)
            4'd0:    r = 23'd2949120;
            4'd1:    r = 23'd1740967;
            4'd2:    r = 23'd919879;
            4'd3:    r = 23'd466945;
            4'd4:    r = 23'd234379;
            4'd5:    r = 23'd117304;
            4'd6:    r = 23'd58666;
            4'd7:    r = 23'd29335;
            4'd8:    r = 23'd14668;
            4'd9:    r = 23'd7334;
            4'd10:   r = 23'd3667;
            4'd11:   r = 23'd1833;
            4'd12:   r = 23'd917;
            4'd13:   r = 23'd458;
            4'd14:   r = 23'd229;
            default: r = 23'd115;
        endcase
        return r;
    endfunction

    // Counter times 100 over 15, truncated.
    function automatic logic [6:0] occ_pct(input logic [3:0] v);
        logic [6:0] p;
        case (v)
            4'd0:    p = 7'd0;
            4'd1:    p = 7'd6;
            4'd2:    p = 7'd13;
            4'd3:    p = 7'd20;
            4'd4:    p = 7'd26;
            4'd5:    p = 7'd33;
            4'd6:    p = 7'd40;
            4'd7:    p = 7'd46;
            4'd8:    p = 7'd53;
            4'd9:    p = 7'd60;
            4'd10:   p = 7'd66;
            4'd11:   p = 7'd73;
            4'd12:   p = 7'd80;
            4'd13:   p = 7'd86;
            4'd14:   p = 7'd93;
            default: p = 7'd100;
        endcase
        return p;
    endfunction

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_CORD  = 11'b00000000100,
        S_SETUP = 11'b00000001000,
        S_DIV   = 11'b00000010000,
        S_SQ    = 11'b00000100000,
        S_POS   = 11'b00001000000,
        S_TEST  = 11'b00010000000,
        S_RD    = 11'b00100000000,
        S_PUSH  = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } t_state;

endpackage
`default_nettype wire

// ===== src/srhgu_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module srhgu_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== src/sonar_ray_himm_grid_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Beat carries
// reading   in         i_valid / o_stall  robot_x, robot_y, heading_q4, beam, range_q4
// cell      out        o_valid / i_stall  cell_index, himm_value, occupancy_pct,
//                                         cell_updated, last
// config    in         i_cfg_we           i_cfg_idx, i_cfg_wdata
//
// After reset the grid is cleared to 7, one cell a cycle, with o_stall high.
// A reading is accepted, rotated by the CORDIC, set up, divided (one shared restoring
// divider, x then y, skipped for a zero-length ray) and squared; then each grid cell
// walked passes position, test, read and write, and hand-off, each cell off the grid
// only position and test, and a closing state ends the reading.
// The grid memory port and the single output register pace the walk; a stalled
// output holds the walk until the beat is taken.
module sonar_ray_himm_grid_update
    import srhgu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [0:0]         i_cfg_idx,
    input  wire logic [7:0]         i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [7:0]  i_robot_x,
    input  wire logic signed [7:0]  i_robot_y,
    input  wire logic signed [12:0] i_heading_q4,
    input  wire logic [2:0]         i_beam,
    input  wire logic [11:0]        i_range_q4,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_cell_index,
    output logic [3:0]              o_himm_value,
    output logic [6:0]              o_occupancy_pct,
    output logic                    o_cell_updated,
    output logic                    o_last
);
    t_state r_state;

    logic [5:0]  r_max_range;
    logic [7:0]  r_half_band;

    logic [ADDR_W-1:0] r_clr;
    logic signed [7:0]  r_rx, r_ry;
    logic signed [13:0] r_t, r_u;
    logic               r_flip;
    logic signed [25:0] r_x, r_y, r_z;
    logic [4:0]         r_k;
    logic signed [7:0]  r_dx, r_dy;
    logic [6:0]         r_steps;
    logic [DIV_N-1:0]   r_dnum;
    logic [7:0]         r_rem;
    logic               r_dsel;
    logic signed [25:0] r_incx, r_incy, r_px, r_py;
    logic [25:0]        r_tsq, r_usq;
    logic [6:0]         r_i, r_n;
    logic [20:0]        r_d2;
    logic               r_ongrid, r_free;
    logic [ADDR_W-1:0]  r_addr;
    logic [3:0]         r_newv;
    logic               r_pv;
    logic [ADDR_W-1:0]  r_pidx;
    logic [3:0]         r_pval;
    logic               r_ov, r_oupd, r_olast;
    logic [ADDR_W-1:0]  r_oidx;
    logic [3:0]         r_oval;

    // Angle wrap and fold into [-90, 90] degrees.
    logic signed [13:0] a0, a1, a2;
    logic               flip;
    always_comb begin
        a0 = beam_angle(i_beam) + 14'(i_heading_q4);
        if (a0 > 14'sd2880) begin
            a1 = a0 - 14'sd5760;
        end else if (a0 <= -14'sd2880) begin
            a1 = a0 + 14'sd5760;
        end else begin
            a1 = a0;
        end
        flip = 1'b0;
        a2   = a1;
        if (a1 > 14'sd1440) begin
            a2   = a1 - 14'sd2880;
            flip = 1'b1;
        end else if (a1 < -14'sd1440) begin
            a2   = a1 + 14'sd2880;
            flip = 1'b1;
        end
    end

    // Shared CORDIC rotation step.
    logic signed [25:0] xs, ys, atn;
    assign xs  = r_x >>> r_k[3:0];
    assign ys  = r_y >>> r_k[3:0];
    assign atn = 26'(atan_q16(r_k[3:0]));

    // End offsets off the Q16 vector, magnitudes truncated after a bias of 64.
    logic signed [25:0] fx, fy, ax, ay;
    logic signed [7:0]  dx, dy;
    logic [6:0]         adx, ady;
    always_comb begin
        fx = r_flip ? -r_x : r_x;
        fy = r_flip ? -r_y : r_y;
        ax = fx[25] ? -fx : fx;
        ay = fy[25] ? -fy : fy;
        dx = fx[25] ? -8'((ax + 26'sd64) >>> 16) : 8'((ax + 26'sd64) >>> 16);
        dy = fy[25] ? -8'((ay + 26'sd64) >>> 16) : 8'((ay + 26'sd64) >>> 16);
        adx = dx[7] ? 7'(-dx) : 7'(dx);
        ady = dy[7] ? 7'(-dy) : 7'(dy);
    end

    // Shared restoring divider step.
    logic [8:0]         rem_sh;
    logic               qbit;
    logic [8:0]         rem_nx;
    logic [DIV_N-1:0]   quot;
    logic signed [25:0] qs;
    logic [6:0]         ad_div;
    always_comb begin
        rem_sh = {r_rem, r_dnum[DIV_N-1]};
        qbit   = rem_sh >= {2'b00, r_steps};
        rem_nx = qbit ? rem_sh - {2'b00, r_steps} : rem_sh;
        quot   = {r_dnum[DIV_N-2:0], qbit};
        qs     = 26'(quot);
        ad_div = r_dy[7] ? 7'(-r_dy) : 7'(r_dy);
    end

    // Walk position to cell, offsets and grid address.
    logic signed [25:0] nxr, nyr;
    logic signed [9:0]  xi, yi, ox, oy;
    logic signed [11:0] gx, gy;
    logic [20:0]        d2;
    logic               ongrid;
    always_comb begin
        nxr = -r_px;
        nyr = -r_py;
        xi  = r_px[25] ? -10'((nxr + 26'sd32768) >>> 16) : 10'((r_px + 26'sd32768) >>> 16);
        yi  = r_py[25] ? -10'((nyr + 26'sd32768) >>> 16) : 10'((r_py + 26'sd32768) >>> 16);
        ox  = xi - 10'(r_rx);
        oy  = yi - 10'(r_ry);
        d2  = (21'(ox) * 21'(ox)) + (21'(oy) * 21'(oy));
        gx  = 12'(GRID_SIDE / 2) + 12'(xi);
        gy  = 12'(GRID_SIDE / 2) + 12'(yi);
        ongrid = !gx[11] && !gy[11] && (gx < 12'(GRID_SIDE)) && (gy < 12'(GRID_SIDE));
    end

    logic [29:0] d2s;
    logic        is_free, is_occ;
    assign d2s     = {1'b0, r_d2, 8'd0};
    assign is_free = (r_t > 14'sd0) && (d2s < {4'd0, r_tsq});
    assign is_occ  = d2s <= {4'd0, r_usq};

    logic [3:0] rdata;
    logic [4:0] hit;
    logic [3:0] newv;
    assign hit  = {1'b0, rdata} + {1'b0, HIMM_HIT};
    assign newv = r_free ? ((rdata > CNT_FLOOR) ? rdata - 4'd1 : CNT_FLOOR)
                         : ((hit > {1'b0, CNT_SAT}) ? CNT_SAT : hit[3:0]);

    logic              we, re;
    logic [ADDR_W-1:0] waddr;
    logic [3:0]        wdata;
    assign we    = (r_state == S_CLEAR) || (r_state == S_RD);
    assign waddr = (r_state == S_CLEAR) ? r_clr : r_addr;
    assign wdata = (r_state == S_CLEAR) ? HIMM_RESET : newv;
    assign re    = (r_state == S_TEST);

    srhgu_ram #(.WIDTH(4), .DEPTH(GRID_DEPTH)) u_grid (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(r_addr),
        .o_rdata(rdata)
    );

    logic       out_free, walk_end, emit;
    logic [6:0] n_n;
    assign out_free = !r_ov || !i_stall;
    assign n_n      = r_n + 7'd1;
    assign walk_end = (r_i == r_steps);
    assign emit     = out_free && (((r_state == S_PUSH) && r_pv) || (r_state == S_FIN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_max_range <= 6'd50;
            r_half_band <= 8'd40;
            r_ov        <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_RANGE: r_max_range <= i_cfg_wdata[5:0];
                    REG_HALF_BAND: r_half_band <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_rx    <= i_robot_x;
                        r_ry    <= i_robot_y;
                        r_t     <= 14'(i_range_q4) - 14'(r_half_band);
                        r_u     <= 14'(i_range_q4) + 14'(r_half_band);
                        r_flip  <= flip;
                        r_x     <= 26'(r_max_range * 22'd39797);
                        r_y     <= '0;
                        r_z     <= 26'(a2) <<< 12;
                        r_k     <= '0;
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (!r_z[25]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atn;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atn;
                    end
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'(CORDIC_N - 1)) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_dx    <= dx;
                    r_dy    <= dy;
                    r_steps <= (ady > adx) ? ady : adx;
                    r_dnum  <= {adx, 16'd0};
                    r_rem   <= '0;
                    r_k     <= '0;
                    r_dsel  <= 1'b0;
                    r_incx  <= '0;
                    r_incy  <= '0;
                    r_state <= ((adx == 7'd0) && (ady == 7'd0)) ? S_SQ : S_DIV;
                end
                S_DIV: begin
                    if (r_k == 5'(DIV_N - 1)) begin
                        r_k   <= '0;
                        r_rem <= '0;
                        if (!r_dsel) begin
                            r_incx <= r_dx[7] ? -qs : qs;
                            r_dnum <= {ad_div, 16'd0};
                            r_dsel <= 1'b1;
                        end else begin
                            r_incy  <= r_dy[7] ? -qs : qs;
                            r_state <= S_SQ;
                        end
                    end else begin
                        r_rem  <= rem_nx[7:0];
                        r_dnum <= quot;
                        r_k    <= r_k + 5'd1;
                    end
                end
                S_SQ: begin
                    r_tsq   <= 26'(26'(r_t) * 26'(r_t));
                    r_usq   <= 26'(26'(r_u) * 26'(r_u));
                    r_px    <= 26'(r_rx) <<< 16;
                    r_py    <= 26'(r_ry) <<< 16;
                    r_i     <= '0;
                    r_n     <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_d2     <= d2;
                    r_ongrid <= ongrid;
                    r_addr   <= {gy[GRID_W-1:0], gx[GRID_W-1:0]};
                    r_state  <= S_TEST;
                end
                S_TEST: begin
                    r_free <= is_free;
                    if (!is_free && !is_occ) begin
                        r_state <= S_FIN;
                    end else if (r_ongrid) begin
                        r_state <= S_RD;
                    end else if (walk_end) begin
                        r_state <= S_FIN;
                    end else begin
                        r_px    <= r_px + r_incx;
                        r_py    <= r_py + r_incy;
                        r_i     <= r_i + 7'd1;
                        r_state <= S_POS;
                    end
                end
                S_RD: begin
                    r_newv  <= newv;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (out_free) begin
                        if (r_pv) begin
                            r_oidx  <= r_pidx;
                            r_oval  <= r_pval;
                            r_oupd  <= 1'b1;
                            r_olast <= 1'b0;
                        end
                        r_pv   <= 1'b1;
                        r_pidx <= r_addr;
                        r_pval <= r_newv;
                        r_n    <= n_n;
                        if (walk_end || (n_n == 7'(MAX_RES))) begin
                            r_state <= S_FIN;
                        end else begin
                            r_px    <= r_px + r_incx;
                            r_py    <= r_py + r_incy;
                            r_i     <= r_i + 7'd1;
                            r_state <= S_POS;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_oidx  <= r_pv ? r_pidx : '0;
                        r_oval  <= r_pv ? r_pval : 4'd0;
                        r_oupd  <= r_pv;
                        r_olast <= 1'b1;
                        r_pv    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_ov;
    assign o_cell_index    = 16'(r_oidx);
    assign o_himm_value    = r_oval;
    assign o_occupancy_pct = occ_pct(r_oval);
    assign o_cell_updated  = r_oupd;
    assign o_last          = r_olast;
endmodule
`default_nettype wire

// ===== src/srhgu_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module srhgu_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_cell_index,
    input wire logic [3:0]  o_himm_value,
    input wire logic [6:0]  o_occupancy_pct,
    input wire logic        o_cell_updated,
    input wire logic        o_last
);
    // A stalled result beat is held.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_cell_index) && $stable(o_last)))
        else $error("stalled result beat changed");

    // A reading is taken alone: the block is busy in the cycle after it.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second reading accepted without a walk");

    // An empty reading reports one closing beat of zeros.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_cell_updated) |->
        (o_last && o_cell_index == 16'd0 && o_himm_value == 4'd0))
        else $error("malformed empty result");

    // Only saturated counters read as fully occupied, and no percent exceeds 100.
    a_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cell_updated) |->
        ((o_occupancy_pct <= 7'd100) && ((o_himm_value == 4'd15) == (o_occupancy_pct == 7'd100))))
        else $error("occupancy percent out of step with counter");
endmodule

bind sonar_ray_himm_grid_update srhgu_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_cell_index   (o_cell_index),
    .o_himm_value   (o_himm_value),
    .o_occupancy_pct(o_occupancy_pct),
    .o_cell_updated (o_cell_updated),
    .o_last         (o_last)
);
`default_nettype wire
